// ===== hw/rtl/tlc_pkg.sv =====
// Tile cache package: slot count, derived widths, operation codes and the
// structs passed between the controller and the row of slot cells. No deps.
package tlc_pkg;

	// Built depth of the cache (1..64)
	localparam int SLOT_COUNT = 16;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int CAP_W      = 5;
	localparam int EXT_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam int LEVEL_W  = 8;
	localparam int COORD_W  = 32;
	localparam int HANDLE_W = 16;
	localparam int TIME_W   = 32;

	typedef enum logic [1:0] {
		OP_GET   = 2'd0,
		OP_ADD   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_CLEAR
	} state_t;

	// Lookup key and tick, held for the whole scan
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [COORD_W-1:0] tile_x;
		logic [COORD_W-1:0] tile_y;
		logic [TIME_W-1:0]  now;
	} query_t;

	// Token that walks the chain one cell per cycle
	typedef struct packed {
		logic                found;
		logic [SLOT_W-1:0]   found_idx;
		logic [HANDLE_W-1:0] found_handle;
		logic [TIME_W-1:0]   bound;
		logic [SLOT_W-1:0]   victim;
	} scan_tok_t;

	// Broadcast write to one slot
	typedef struct packed {
		logic                key_we;
		logic                time_we;
		logic [SLOT_W-1:0]   idx;
		logic [LEVEL_W-1:0]  level;
		logic [COORD_W-1:0]  tile_x;
		logic [COORD_W-1:0]  tile_y;
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   atime;
	} slot_wr_t;

endpackage

// ===== hw/rtl/tlc_cell.sv =====
// One cache slot: holds key, handle and access time, and updates the scan
// token on its way to the next cell. Depends on tlc_pkg.
module tlc_cell (
	input  logic                        clk,
	input  logic [tlc_pkg::SLOT_W-1:0]  idx,
	input  logic [tlc_pkg::CNT_W-1:0]   fill,
	input  tlc_pkg::query_t             qry,
	input  tlc_pkg::slot_wr_t           wr,
	input  tlc_pkg::scan_tok_t          tok_in,
	output tlc_pkg::scan_tok_t          tok_out,
	output logic [tlc_pkg::HANDLE_W-1:0] handle
);
	import tlc_pkg::*;

	logic [LEVEL_W-1:0]  level_q;
	logic [COORD_W-1:0]  x_q;
	logic [COORD_W-1:0]  y_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [TIME_W-1:0]   time_q;
	scan_tok_t           tok_q;
	scan_tok_t           tok_d;
	logic                active;
	logic                match;

	assign active = CNT_W'(idx) < fill;
	assign match  = (level_q == qry.level) && (x_q == qry.tile_x) && (y_q == qry.tile_y);

	// first match wins; strict-less keeps the earliest oldest slot
	always_comb begin
		tok_d = tok_in;
		if (active && !tok_in.found && match) begin
			tok_d.found        = 1'b1;
			tok_d.found_idx    = idx;
			tok_d.found_handle = handle_q;
		end
		if (active && (time_q < tok_in.bound)) begin
			tok_d.bound  = time_q;
			tok_d.victim = idx;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (wr.key_we && (wr.idx == idx)) begin
			level_q  <= wr.level;
			x_q      <= wr.tile_x;
			y_q      <= wr.tile_y;
			handle_q <= wr.handle;
		end
		if (wr.time_we && (wr.idx == idx)) begin
			time_q <= wr.atime;
		end
	end

	assign tok_out = tok_q;
	assign handle  = handle_q;

endmodule

// ===== hw/rtl/tile_cache_lru_lookup.sv =====
// Tile cache top level: stream ports, capacity register, controller and the
// chain of slot cells. Depends on tlc_pkg and tlc_cell.
//
// Usage: one input word per operation on s_axis. tuser carries the operation
// (get, add, clear); tdata carries the key, the handle to store and the tick.
// Each word gives result words on m_axis; tlast marks the final one.
// Get and add send a token down the row of SLOT_COUNT cells, one cell per
// cycle. The result word is loaded into the output register once the token
// has left the last cell, and the next input word is taken after the return
// to idle. A clear gives one word per filled slot, one per cycle while the
// receiver is ready, or one empty word if nothing is stored. Unused operation
// codes give one empty word. One operation is in flight at a time; the result
// sits in an output register, so a stalled receiver holds only the final
// result step and the clear walk. cfg_wr_en/cfg_wr_data set the capacity;
// write it only while idle. Reset empties the cache and sets capacity to 16;
// slot contents are not cleared and are never read before being written.
module tile_cache_lru_lookup (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [4:0]   cfg_wr_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// level[7:0], tile_x[39:8], tile_y[71:40], tile_handle[87:72], now_ticks[119:88]
	input  logic [119:0] s_axis_tdata,
	// operation[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found_handle[15:0], released_handle[31:16]
	output logic [31:0]  m_axis_tdata,
	// hit[0], released_valid[1]
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);
	import tlc_pkg::*;

	state_t              state_q, state_d;
	logic [CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [1:0]          op_q;
	query_t              qry_q;
	logic [HANDLE_W-1:0] hnd_q;
	logic [SLOT_W-1:0]   scan_cnt_q, scan_cnt_d;
	logic [SLOT_W-1:0]   clr_idx_q, clr_idx_d;

	logic                out_vld_q;
	logic [31:0]         out_data_q;
	logic [1:0]          out_user_q;
	logic                out_last_q;
	logic                out_load;
	logic [31:0]         out_data_d;
	logic [1:0]          out_user_d;
	logic                out_last_d;
	logic                out_free;

	scan_tok_t           tok [SLOT_COUNT+1];
	logic [HANDLE_W-1:0] cell_handle [SLOT_COUNT];
	slot_wr_t            wr;
	scan_tok_t           res;
	logic [EXT_W-1:0]    eff_cap;
	logic                full;
	logic                in_acc;
	logic                clr_last;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;
	assign res      = tok[SLOT_COUNT];

	// capacity clamp: 0 acts as 1, above the depth acts as the depth
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = EXT_W'(1);
		end else if (EXT_W'(cap_q) > EXT_W'(SLOT_COUNT)) begin
			eff_cap = EXT_W'(SLOT_COUNT);
		end else begin
			eff_cap = EXT_W'(cap_q);
		end
	end
	assign full     = EXT_W'(cnt_q) >= eff_cap;
	assign clr_last = (CNT_W'(clr_idx_q) + CNT_W'(1)) == cnt_q;

	// token injected at the head of the chain
	always_comb begin
		tok[0]              = '0;
		tok[0].bound        = qry_q.now;
	end

	// row of slot cells
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		tlc_cell u_cell (
			.clk     (clk),
			.idx     (SLOT_W'(i)),
			.fill    (cnt_q),
			.qry     (qry_q),
			.wr      (wr),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.handle  (cell_handle[i])
		);
	end

	// controller: next state, slot writes and result words
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		scan_cnt_d = scan_cnt_q;
		clr_idx_d  = clr_idx_q;
		out_load   = 1'b0;
		out_data_d = '0;
		out_user_d = '0;
		out_last_d = 1'b1;
		wr         = '0;
		wr.level   = qry_q.level;
		wr.tile_x  = qry_q.tile_x;
		wr.tile_y  = qry_q.tile_y;
		wr.handle  = hnd_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					scan_cnt_d = '0;
					clr_idx_d  = '0;
					priority if ((s_axis_tuser == OP_GET) || (s_axis_tuser == OP_ADD)) begin
						state_d = ST_SCAN;
					end else if ((s_axis_tuser == OP_CLEAR) && (cnt_q != '0)) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				scan_cnt_d = scan_cnt_q + SLOT_W'(1);
				if (scan_cnt_q == SLOT_W'(SLOT_COUNT - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					unique case (op_q)
						OP_GET: begin
							if (res.found) begin
								out_user_d[0]     = 1'b1;
								out_data_d[15:0]  = res.found_handle;
								wr.time_we        = 1'b1;
								wr.idx            = res.found_idx;
								wr.atime          = qry_q.now;
							end
						end
						OP_ADD: begin
							wr.key_we  = 1'b1;
							wr.time_we = 1'b1;
							wr.atime   = '0;
							if (full) begin
								wr.idx            = res.victim;
								out_user_d[1]     = 1'b1;
								out_data_d[31:16] = cell_handle[res.victim];
							end else begin
								wr.idx = cnt_q[SLOT_W-1:0];
								cnt_d  = cnt_q + CNT_W'(1);
							end
						end
						default: begin
							// empty clear or unused code: one empty word
						end
					endcase
				end
			end
			ST_CLEAR: begin
				if (out_free) begin
					out_load          = 1'b1;
					out_user_d[1]     = 1'b1;
					out_data_d[31:16] = cell_handle[clr_idx_q];
					out_last_d        = clr_last;
					if (clr_last) begin
						cnt_d   = '0;
						state_d = ST_IDLE;
					end else begin
						clr_idx_d = clr_idx_q + SLOT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= CAP_W'(16);
			cnt_q      <= '0;
			scan_cnt_q <= '0;
			clr_idx_q  <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			scan_cnt_q <= scan_cnt_d;
			clr_idx_q  <= clr_idx_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// captured input word and result word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q         <= s_axis_tuser;
			qry_q.level  <= s_axis_tdata[7:0];
			qry_q.tile_x <= s_axis_tdata[39:8];
			qry_q.tile_y <= s_axis_tdata[71:40];
			hnd_q        <= s_axis_tdata[87:72];
			qry_q.now    <= s_axis_tdata[119:88];
		end
		if (out_load) begin
			out_data_q <= out_data_d;
			out_user_q <= out_user_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== verif/tb_tile_cache_lru_lookup.sv =====
`timescale 1ns / 1ps
// Testbench for tile_cache_lru_lookup: directed and random get/add/clear words
// on the input stream, results checked against a cycle-free cache model.
// Depends on tlc_pkg and the tile_cache_lru_lookup RTL.
module tb_tile_cache_lru_lookup;
	import tlc_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         HOLD_CYCLES  = 400;
	localparam int         DRAIN_CYCLES = SLOT_COUNT + 8;
	localparam int         RANDOM_WORDS = 50;
	localparam int         PHASES       = 5;

	typedef struct {
		logic [1:0]          op;
		logic [LEVEL_W-1:0]  level;
		logic [COORD_W-1:0]  tile_x;
		logic [COORD_W-1:0]  tile_y;
		logic [HANDLE_W-1:0] tile_handle;
		logic [TIME_W-1:0]   now_ticks;
	} tile_req_t;

	typedef struct {
		logic                hit;
		logic [HANDLE_W-1:0] found_handle;
		logic                released_valid;
		logic [HANDLE_W-1:0] released_handle;
		logic                last;
	} cache_rsp_t;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         cfg_wr_en     = 1'b0;
	logic [4:0]   cfg_wr_data   = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata  = '0;
	logic [1:0]   s_axis_tuser  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;

	// Cache model state
	logic [LEVEL_W-1:0]  slot_level  [SLOT_COUNT];
	logic [COORD_W-1:0]  slot_col    [SLOT_COUNT];
	logic [COORD_W-1:0]  slot_row    [SLOT_COUNT];
	logic [HANDLE_W-1:0] slot_handle [SLOT_COUNT];
	logic [TIME_W-1:0]   slot_atime  [SLOT_COUNT];
	int                  fill_count = 0;
	logic [4:0]          cache_capacity = 5'd16;

	cache_rsp_t expected_rsp[$];
	tile_req_t  tx_queue[$];
	tile_req_t  drv_word;
	bit         drv_busy    = 1'b0;
	bit         rx_hold     = 1'b0;
	bit         no_idle     = 1'b0;
	int         tx_gap      = 0;
	int         rx_gap      = 0;
	int         idle_pct    = 20;
	int         words_taken = 0;
	int         cycle_count = 0;
	int         fail_count  = 0;
	logic [TIME_W-1:0] tick_now = '0;

	tile_cache_lru_lookup i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic cache_rsp_t make_rsp(input logic hit, input logic [HANDLE_W-1:0] found,
			input logic rel_valid, input logic [HANDLE_W-1:0] rel_handle, input logic last);
		cache_rsp_t r;
		r.hit             = hit;
		r.found_handle    = found;
		r.released_valid  = rel_valid;
		r.released_handle = rel_handle;
		r.last            = last;
		return r;
	endfunction

	// Expected result words for one accepted word; updates the cache model
	task automatic predict_cache(input tile_req_t w);
		int                slot;
		int                eff_cap;
		logic [TIME_W-1:0] bound;
		begin
			eff_cap = (cache_capacity == 0) ? 1 :
				(cache_capacity > SLOT_COUNT) ? SLOT_COUNT : int'(cache_capacity);
			case (w.op)
			OP_GET: begin
				slot = -1;
				for (int i = 0; i < fill_count; i++)
					if (slot < 0 && slot_level[i] == w.level && slot_col[i] == w.tile_x &&
							slot_row[i] == w.tile_y)
						slot = i;
				if (slot >= 0) begin
					slot_atime[slot] = w.now_ticks;
					expected_rsp.push_back(make_rsp(1'b1, slot_handle[slot], 1'b0, '0, 1'b1));
				end else begin
					expected_rsp.push_back(make_rsp(1'b0, '0, 1'b0, '0, 1'b1));
				end
			end
			OP_ADD: begin
				if (fill_count >= eff_cap) begin
					// strict-less scan from the current tick, slot 0 as fallback
					slot  = 0;
					bound = w.now_ticks;
					for (int i = 0; i < fill_count; i++)
						if (slot_atime[i] < bound) begin
							slot  = i;
							bound = slot_atime[i];
						end
					expected_rsp.push_back(make_rsp(1'b0, '0, 1'b1, slot_handle[slot], 1'b1));
				end else begin
					slot = fill_count;
					fill_count++;
					expected_rsp.push_back(make_rsp(1'b0, '0, 1'b0, '0, 1'b1));
				end
				slot_level[slot]  = w.level;
				slot_col[slot]    = w.tile_x;
				slot_row[slot]    = w.tile_y;
				slot_handle[slot] = w.tile_handle;
				slot_atime[slot]  = '0;
			end
			OP_CLEAR: begin
				if (fill_count == 0)
					expected_rsp.push_back(make_rsp(1'b0, '0, 1'b0, '0, 1'b1));
				for (int i = 0; i < fill_count; i++)
					expected_rsp.push_back(make_rsp(1'b0, '0, 1'b1, slot_handle[i],
						i == fill_count - 1));
				fill_count = 0;
			end
			default: begin
				expected_rsp.push_back(make_rsp(1'b0, '0, 1'b0, '0, 1'b1));
			end
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [HANDLE_W-1:0] want,
			input logic [HANDLE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic queue_word(input logic [1:0] op, input logic [LEVEL_W-1:0] level,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [HANDLE_W-1:0] handle, input logic [TIME_W-1:0] now_ticks);
		tile_req_t w;
		begin
			w.op          = op;
			w.level       = level;
			w.tile_x      = x;
			w.tile_y      = y;
			w.tile_handle = handle;
			w.now_ticks   = now_ticks;
			tx_queue.push_back(w);
		end
	endtask

	// Random words over a small key pool so that gets hit and adds evict; ends in a clear
	task automatic queue_random_words(input int count, input int pool_size);
		tile_req_t key_pool[$];
		tile_req_t k;
		tile_req_t w;
		int        sel;
		begin
			for (int j = 0; j < pool_size; j++) begin
				k.level  = LEVEL_W'($urandom_range(0, 255));
				k.tile_x = $urandom;
				k.tile_y = $urandom;
				// near-miss keys: one field differs from the previous key
				if (j > 0 && $urandom_range(0, 9) < 3) begin
					k = key_pool[j-1];
					case ($urandom_range(0, 2))
					0:       k.level[$urandom_range(0, LEVEL_W-1)] ^= 1'b1;
					1:       k.tile_x[$urandom_range(0, COORD_W-1)] ^= 1'b1;
					default: k.tile_y[$urandom_range(0, COORD_W-1)] ^= 1'b1;
					endcase
				end
				key_pool.push_back(k);
			end
			for (int n = 0; n < count; n++) begin
				w = key_pool[$urandom_range(0, pool_size - 1)];
				w.tile_handle = HANDLE_W'($urandom_range(0, 65535));
				case ($urandom_range(0, 19))
				0:       w.now_ticks = '0;
				1:       w.now_ticks = $urandom;
				default: begin
					tick_now    = tick_now + $urandom_range(0, 50);
					w.now_ticks = tick_now;
				end
				endcase
				sel = $urandom_range(0, 99);
				if (sel < 45) begin
					w.op = OP_GET;
				end else if (sel < 88) begin
					w.op = OP_ADD;
				end else if (sel < 94) begin
					w.op = OP_CLEAR;
				end else if (sel < 97) begin
					w.op = OP_UNUSED;
				end else begin
					w.op     = OP_GET;
					w.level  = LEVEL_W'($urandom_range(0, 255));
					w.tile_x = $urandom;
					w.tile_y = $urandom;
				end
				tx_queue.push_back(w);
			end
			queue_word(OP_CLEAR, '0, '0, '0, '0, tick_now);
		end
	endtask

	task automatic wait_idle();
		while (tx_queue.size() != 0 || drv_busy || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Input driver: presents the next pending word at the falling edge
	always @(negedge clk) begin
		if (arst_n && !drv_busy) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (tx_queue.size() > 0) begin
				drv_word = tx_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= drv_word.op;
				s_axis_tdata  <= {drv_word.now_ticks, drv_word.tile_handle, drv_word.tile_y,
					drv_word.tile_x, drv_word.level};
				drv_busy = 1'b1;
				if ($urandom_range(0, 99) < idle_pct)
					tx_gap = $urandom_range(1, 13);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stall bursts plus the long hold-off
	always @(negedge clk) begin
		if (!arst_n || rx_hold) begin
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 99) < idle_pct)
				rx_gap = $urandom_range(1, 13);
		end
	end

	// Accepted words and register writes feed the model
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_cache(drv_word);
				drv_busy = 1'b0;
				words_taken++;
			end
			if (cfg_wr_en)
				cache_capacity = cfg_wr_data;
			// idle density is redrawn at intervals set by the cycle counter, with quiet stretches
			cycle_count++;
			if (no_idle) begin
				idle_pct = 0;
			end else if (cycle_count % 64 == 0) begin
				case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 15;
				default: idle_pct = 40;
				endcase
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin : result_check
		cache_rsp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rsp.size() == 0) begin
				$error("result word with none expected: tdata %h tuser %b tlast %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fail_count++;
			end else begin
				want = expected_rsp.pop_front();
				check_field("hit", want.hit, m_axis_tuser[0]);
				check_field("found_handle", want.found_handle, m_axis_tdata[15:0]);
				check_field("released_valid", want.released_valid, m_axis_tuser[1]);
				check_field("released_handle", want.released_handle, m_axis_tdata[31:16]);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	// Long receiver hold-off once the random part is under way
	initial begin
		while (words_taken < 40)
			@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("tb_tile_cache_lru_lookup: FAIL");
		$finish;
	end

	// Stimulus sequence
	initial begin
		logic [4:0] cap_plan [PHASES];
		int         eff_cap;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: three slots, field extremes, eviction corner cases
		write_capacity(5'd3);
		queue_word(OP_CLEAR, 8'd0, 32'd0, 32'd0, 16'd0, 32'd0);
		queue_word(OP_GET, 8'd1, 32'd2, 32'd3, 16'd0, 32'd1);
		queue_word(OP_UNUSED, 8'd0, 32'd0, 32'd0, 16'd0, 32'd0);
		queue_word(OP_ADD, 8'd0, 32'h8000_0000, 32'h7fff_ffff, 16'h0000, 32'd0);
		queue_word(OP_ADD, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 16'hffff, 32'hffff_ffff);
		queue_word(OP_ADD, 8'd7, 32'hffff_ffff, 32'd0, 16'h1234, 32'd5);
		queue_word(OP_GET, 8'd0, 32'h8000_0000, 32'h7fff_ffff, 16'd0, 32'hffff_ffff);
		queue_word(OP_GET, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 16'd0, 32'd100);
		// level differs only: must miss
		queue_word(OP_GET, 8'd1, 32'h8000_0000, 32'h7fff_ffff, 16'd0, 32'd101);
		// full: slot 2 has the oldest time under the tick
		queue_word(OP_ADD, 8'd9, 32'd10, 32'd11, 16'h5555, 32'd50);
		// tick 0: no slot is strictly older, slot 0 goes
		queue_word(OP_ADD, 8'd10, 32'd12, 32'd13, 16'haaaa, 32'd0);
		// duplicate of the key in slot 1; first match wins afterwards
		queue_word(OP_ADD, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 16'h0f0f, 32'd200);
		queue_word(OP_GET, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 16'd0, 32'd300);
		queue_word(OP_UNUSED, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
		queue_word(OP_CLEAR, 8'd0, 32'd0, 32'd0, 16'd0, 32'd400);
		queue_word(OP_CLEAR, 8'd0, 32'd0, 32'd0, 16'd0, 32'd401);
		wait_idle();

		// capacity 0 behaves as one slot
		write_capacity(5'd0);
		queue_word(OP_ADD, 8'd3, 32'd1, 32'd1, 16'h0101, 32'd10);
		queue_word(OP_ADD, 8'd4, 32'd2, 32'd2, 16'h0202, 32'd20);
		queue_word(OP_GET, 8'd3, 32'd1, 32'd1, 16'd0, 32'd30);
		queue_word(OP_GET, 8'd4, 32'd2, 32'd2, 16'd0, 32'd40);
		queue_word(OP_CLEAR, 8'd0, 32'd0, 32'd0, 16'd0, 32'd50);

		// random phases; the last one runs without idling
		cap_plan[0] = 5'd31;
		cap_plan[1] = 5'd1;
		cap_plan[2] = 5'($urandom_range(2, 8));
		cap_plan[3] = 5'd16;
		cap_plan[4] = 5'($urandom_range(0, 31));
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			if (p == PHASES - 1)
				no_idle = 1'b1;
			write_capacity(cap_plan[p]);
			eff_cap = (cap_plan[p] == 0) ? 1 :
				(cap_plan[p] > SLOT_COUNT) ? SLOT_COUNT : int'(cap_plan[p]);
			queue_random_words(RANDOM_WORDS, eff_cap + 1 + $urandom_range(0, 4));
		end
		wait_idle();

		if (fail_count == 0 && expected_rsp.size() == 0)
			$display("tb_tile_cache_lru_lookup: PASS");
		else
			$display("tb_tile_cache_lru_lookup: FAIL");
		$finish;
	end

endmodule
